FILE: src/saf_pkg.sv
// Shared types, constants and tables for the SAFER-SK128 core.
// Holds the exponent, logarithm and key bias tables, built at elaboration.
// No dependencies.
`default_nettype none
package saf_pkg;

    localparam int MAX_ROUND_COUNT = 13;
    localparam int KEY_ROWS        = MAX_ROUND_COUNT + 1;
    localparam int ROW_AW          = $clog2(KEY_ROWS);
    localparam int ROW_W           = 128;

    localparam logic [1:0] CFG_KEY_UPPER   = 2'd0;
    localparam logic [1:0] CFG_KEY_LOWER   = 2'd1;
    localparam logic [1:0] CFG_ROUND_COUNT = 2'd2;

    typedef logic [255:0][7:0]              t_tab;
    typedef logic [MAX_ROUND_COUNT-1:0][15:0][7:0] t_bias;

    typedef enum logic [1:0] {
        ST_SCHED,
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ROW_AW-1:0] addr;
        logic [ROW_W-1:0]  data;
    } t_wr;

    function automatic t_tab f_exp();
        t_tab t;
        int   v;
        v = 1;
        for (int x = 0; x < 256; x++) begin
            t[x] = v[7:0];
            v = (v * 45) % 257;
        end
        return t;
    endfunction

    function automatic t_tab f_log();
        t_tab t;
        int   v;
        v = 1;
        for (int x = 0; x < 256; x++) begin
            t[v & 255] = x[7:0];
            v = (v * 45) % 257;
        end
        return t;
    endfunction

    localparam t_tab EXP_T = f_exp();
    localparam t_tab LOG_T = f_log();

    function automatic t_bias f_bias();
        t_bias b;
        int    idx;
        for (int r = 0; r < MAX_ROUND_COUNT; r++) begin
            for (int k = 0; k < 16; k++) begin
                if (k < 8) begin
                    idx = (18 * (r + 1) + k + 1) & 255;
                end else begin
                    idx = (18 * (r + 1) + k + 2) & 255;
                end
                b[r][k] = EXP_T[EXP_T[idx]];
            end
        end
        return b;
    endfunction

    localparam t_bias BIAS_T = f_bias();

    function automatic logic [3:0] f_mod9(logic [5:0] x);
        logic [5:0] y;
        y = x;
        for (int s = 0; s < 3; s++) begin
            if (y >= 6'd9) begin
                y = y - 6'd9;
            end
        end
        return y[3:0];
    endfunction

endpackage
`default_nettype wire

FILE: src/saf_if.sv
// Valid/ready channel interfaces for blocks entering and leaving the core.
// No dependencies.
`default_nettype none
interface saf_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [63:0] block_in;
    modport source (output valid, output action, output block_in, input ready);
    modport sink (input valid, input action, input block_in, output ready);
endinterface

interface saf_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_out;
    modport source (output valid, output block_out, input ready);
    modport sink (input valid, input block_out, output ready);
endinterface
`default_nettype wire

FILE: src/saf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
`default_nettype none
module saf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: src/saf_key_sched.sv
// Key schedule sequencer: writes one 16-byte round key row per cycle.
// Depends on saf_pkg.
`default_nettype none
module saf_key_sched (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_key_upper,
    input  wire logic [63:0] i_key_lower,
    output saf_pkg::t_wr     o_wr,
    output logic             o_done
);
    import saf_pkg::*;

    logic                r_load;
    logic                r_busy;
    logic [ROW_AW-1:0]   r_cnt;
    logic [17:0][7:0]    r_kb;
    logic [17:0][7:0]    n_kb;
    logic [63:0]         r_prev;
    logic [17:0][7:0]    kb_init;
    logic [63:0]         grp_a;
    logic [63:0]         grp_b;
    logic                last;

    always_comb begin
        logic [7:0] xu;
        logic [7:0] xl;
        logic [7:0] kbyte;
        xu = '0;
        xl = '0;
        for (int k = 0; k < 8; k++) begin
            kbyte          = i_key_upper[63-8*k -: 8];
            kb_init[k]     = {kbyte[2:0], kbyte[7:3]};
            xu             = xu ^ kb_init[k];
            kb_init[9+k]   = i_key_lower[63-8*k -: 8];
            xl             = xl ^ kb_init[9+k];
        end
        kb_init[8]  = xu;
        kb_init[17] = xl;
    end

    always_comb begin
        logic [5:0] c2;
        for (int k = 0; k < 18; k++) begin
            n_kb[k] = {r_kb[k][1:0], r_kb[k][7:2]};
        end
        c2 = {1'b0, r_cnt, 1'b0};
        for (int k = 0; k < 8; k++) begin
            grp_a[63-8*k -: 8] = n_kb[f_mod9(c2 + 6'(k + 1))]
                + BIAS_T[r_cnt][k];
            grp_b[63-8*k -: 8] = n_kb[5'd9 + 5'(f_mod9(c2 + 6'(k + 2)))]
                + BIAS_T[r_cnt][8+k];
        end
    end

    assign last = (r_cnt == ROW_AW'(MAX_ROUND_COUNT));

    always_comb begin
        o_wr.we   = r_busy && !r_load;
        o_wr.addr = r_cnt;
        o_wr.data = last ? {r_prev, 64'd0} : {r_prev, grp_a};
        o_done    = r_busy && !r_load && last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= 1'b1;
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_load <= 1'b1;
            r_busy <= 1'b1;
        end else if (r_load) begin
            r_load <= 1'b0;
            r_cnt  <= '0;
            r_kb   <= kb_init;
            r_prev <= i_key_lower;
        end else if (r_busy) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt  <= r_cnt + 1'b1;
                r_kb   <= n_kb;
                r_prev <= grp_b;
            end
        end
    end
endmodule
`default_nettype wire

FILE: src/saf_round.sv
// One round or output key transform of SAFER-SK128 in either direction.
// Depends on saf_pkg for the exponent and logarithm tables.
`default_nettype none
module saf_round (
    input  wire logic         i_dec,
    input  wire logic         i_xf,
    input  wire logic [63:0]  i_state,
    input  wire logic [127:0] i_key,
    output logic      [63:0]  o_next,
    output logic      [63:0]  o_result
);
    import saf_pkg::*;

    always_comb begin
        logic [7:0] v [8];
        logic [7:0] a [8];
        logic [7:0] b [8];
        logic [7:0] t0;
        logic [7:0] t1;
        for (int i = 0; i < 8; i++) begin
            v[i] = i_state[63-8*i -: 8];
            a[i] = i_key[127-8*i -: 8];
            b[i] = i_key[63-8*i -: 8];
        end
        t0 = '0;
        t1 = '0;
        if (!i_dec && i_xf) begin
            v[0] = v[0] ^ a[0]; v[1] = v[1] + a[1];
            v[2] = v[2] + a[2]; v[3] = v[3] ^ a[3];
            v[4] = v[4] ^ a[4]; v[5] = v[5] + a[5];
            v[6] = v[6] + a[6]; v[7] = v[7] ^ a[7];
        end else if (!i_dec) begin
            for (int i = 0; i < 8; i++) begin
                if (i == 0 || i == 3 || i == 4 || i == 7) begin
                    v[i] = EXP_T[v[i] ^ a[i]] + b[i];
                end else begin
                    v[i] = LOG_T[v[i] + a[i]] ^ b[i];
                end
            end
            v[1] = v[1] + v[0]; v[3] = v[3] + v[2]; v[5] = v[5] + v[4]; v[7] = v[7] + v[6];
            v[0] = v[0] + v[1]; v[2] = v[2] + v[3]; v[4] = v[4] + v[5]; v[6] = v[6] + v[7];
            v[2] = v[2] + v[0]; v[6] = v[6] + v[4]; v[3] = v[3] + v[1]; v[7] = v[7] + v[5];
            v[0] = v[0] + v[2]; v[4] = v[4] + v[6]; v[1] = v[1] + v[3]; v[5] = v[5] + v[7];
            v[7] = v[7] + v[3];
            t1   = v[3] + v[7];
            v[3] = v[1] + v[5];
            t0   = v[1] + v[3];
            v[1] = v[0] + v[4];
            v[0] = v[0] + v[1];
            v[5] = v[2] + v[6];
            v[4] = v[2] + v[5];
            v[2] = t0;
            v[6] = t1;
        end else if (i_xf) begin
            t0   = v[1];
            t1   = v[2];
            v[0] = v[0] ^ a[0];
            v[1] = t1 - a[2];
            v[2] = v[4] ^ a[4];
            v[4] = t0 - a[1];
            t0   = v[3];
            v[3] = v[6] - a[6];
            v[6] = v[5] - a[5];
            v[5] = t0 ^ a[3];
            v[7] = v[7] ^ a[7];
        end else begin
            v[0] = v[0] - v[4]; v[1] = v[1] - v[5]; v[2] = v[2] - v[6]; v[3] = v[3] - v[7];
            v[4] = v[4] - v[0]; v[5] = v[5] - v[1]; v[6] = v[6] - v[2]; v[7] = v[7] - v[3];
            v[0] = v[0] - v[2]; v[4] = v[4] - v[6]; v[1] = v[1] - v[3]; v[5] = v[5] - v[7];
            v[2] = v[2] - v[0]; v[6] = v[6] - v[4]; v[3] = v[3] - v[1]; v[7] = v[7] - v[5];
            v[0] = v[0] - v[1]; v[2] = v[2] - v[3]; v[4] = v[4] - v[5]; v[6] = v[6] - v[7];
            v[1] = v[1] - v[0]; v[3] = v[3] - v[2]; v[5] = v[5] - v[4]; v[7] = v[7] - v[6];
            v[0] = LOG_T[v[0] - b[0]] ^ a[0];
            v[7] = LOG_T[v[7] - b[7]] ^ a[7];
            t0   = LOG_T[v[4] - b[4]] ^ a[4];
            v[4] = EXP_T[v[1] ^ b[1]] - a[1];
            v[1] = EXP_T[v[2] ^ b[2]] - a[2];
            t1   = EXP_T[v[5] ^ b[5]] - a[5];
            v[5] = LOG_T[v[3] - b[3]] ^ a[3];
            v[3] = EXP_T[v[6] ^ b[6]] - a[6];
            v[2] = t0;
            v[6] = t1;
        end
        for (int i = 0; i < 8; i++) begin
            o_next[63-8*i -: 8] = v[i];
        end
        if (i_dec) begin
            o_result = {v[0], v[4], v[1], v[5], v[2], v[6], v[3], v[7]};
        end else begin
            o_result = o_next;
        end
    end
endmodule
`default_nettype wire

FILE: src/safer_sk128_block_cipher_core.sv
// SAFER-SK128 block cipher core: top level with control and round key store.
// Usage: the block channel i_blk carries a direction (0 encrypt, 1 decrypt)
// and a 64-bit block; o_blk returns the transformed block. The key is set
// through the write port: index 0 upper key half, 1 lower key half, 2 round
// count (0 counts as 1, above 13 as 13). Writing either key half starts the
// key schedule, which fills the round key RAM one row per cycle; no block is
// taken while it runs. Write configuration only while idle.
// A block of n rounds is processed as one step per round plus the output key
// transform before its result is presented, each step reading one round key
// row through the single RAM read port.
// The next block is taken while a result waits; the core then holds before
// its final step until o_blk is free. No new block is taken while one is
// still in its rounds.
// Synchronous active-low reset loads the all-zero key, round count 10, and
// runs the key schedule before the first block is taken.
// Depends on saf_pkg, saf_if, saf_ram, saf_key_sched and saf_round.
`default_nettype none
module safer_sk128_block_cipher_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    saf_in_if.sink           i_blk,
    saf_out_if.source        o_blk
);
    import saf_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [63:0]       r_key_upper;
    logic [63:0]       r_key_lower;
    logic [3:0]        r_round_count;
    logic [3:0]        rounds;
    logic              r_dec;
    logic [3:0]        r_step;
    logic [63:0]       r_v;
    logic              r_out_valid;
    logic [63:0]       r_out;
    logic [ROW_AW-1:0] raddr;
    logic [ROW_W-1:0]  rdata;
    t_wr               wr;
    logic              sched_done;
    logic              key_write;
    logic              in_xfer;
    logic              last;
    logic              advance;
    logic              xf;
    logic [63:0]       rnd_next;
    logic [63:0]       rnd_result;

    assign rounds = (r_round_count == 4'd0) ? 4'd1 :
                    (r_round_count > 4'(MAX_ROUND_COUNT)) ? 4'(MAX_ROUND_COUNT) :
                    r_round_count;

    assign key_write = i_cfg_we && (i_cfg_idx == CFG_KEY_UPPER || i_cfg_idx == CFG_KEY_LOWER);
    assign in_xfer   = i_blk.valid && i_blk.ready;
    assign last      = (r_step == rounds);
    assign advance   = !last || !r_out_valid || o_blk.ready;
    assign xf        = r_dec ? (r_step == 4'd0) : last;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_SCHED: if (sched_done && !key_write) n_state = ST_IDLE;
            ST_IDLE: begin
                if (key_write) begin
                    n_state = ST_SCHED;
                end else if (in_xfer) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN:   if (last && advance) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_blk.ready = 1'b0;
        raddr       = '0;
        case (r_state)
            ST_IDLE: begin
                i_blk.ready = !i_cfg_we;
                raddr       = i_blk.action ? ROW_AW'(rounds) : '0;
            end
            ST_RUN: begin
                if (advance && !last) begin
                    raddr = r_dec ? ROW_AW'(rounds - r_step - 4'd1) : ROW_AW'(r_step + 4'd1);
                end else begin
                    raddr = r_dec ? ROW_AW'(rounds - r_step) : ROW_AW'(r_step);
                end
            end
            default: raddr = '0;
        endcase
    end

    assign o_blk.valid     = r_out_valid;
    assign o_blk.block_out = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_SCHED;
            r_key_upper   <= '0;
            r_key_lower   <= '0;
            r_round_count <= 4'd10;
            r_out_valid   <= 1'b0;
            r_step        <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KEY_UPPER:   r_key_upper   <= i_cfg_data;
                    CFG_KEY_LOWER:   r_key_lower   <= i_cfg_data;
                    CFG_ROUND_COUNT: r_round_count <= i_cfg_data[3:0];
                    default:         r_round_count <= r_round_count;
                endcase
            end
            if (r_state == ST_RUN && advance && last) begin
                r_out_valid <= 1'b1;
            end else if (o_blk.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_IDLE && in_xfer) begin
                r_step <= '0;
            end else if (r_state == ST_RUN && advance && !last) begin
                r_step <= r_step + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_xfer) begin
            r_dec <= i_blk.action;
            r_v   <= i_blk.block_in;
        end else if (r_state == ST_RUN && advance) begin
            r_v <= rnd_next;
            if (last) begin
                r_out <= rnd_result;
            end
        end
    end

    saf_key_sched u_sched (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (key_write),
        .i_key_upper (r_key_upper),
        .i_key_lower (r_key_lower),
        .o_wr        (wr),
        .o_done      (sched_done)
    );

    saf_ram #(
        .WIDTH (ROW_W),
        .DEPTH (KEY_ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr.we),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    saf_round u_round (
        .i_dec    (r_dec),
        .i_xf     (xf),
        .i_state  (r_v),
        .i_key    (rdata),
        .o_next   (rnd_next),
        .o_result (rnd_result)
    );

`ifndef ASSERT_OFF
    a_wr_only_sched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.we |-> r_state == ST_SCHED)
        else $error("round key write outside key schedule");
    a_xfer_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> r_state == ST_IDLE)
        else $error("block transfer while busy");
    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && last && advance) |=> r_out_valid)
        else $error("finished block not presented");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> r_step <= rounds)
        else $error("step counter past round count");
`endif
endmodule
`default_nettype wire
